// ===== rtl/sbmq_pkg.sv =====
// Shared types, constants and helpers for the shared-buffer multi-queue.
`default_nettype none
package sbmq_pkg;

  localparam int ENTRIES = 64;
  localparam int QUEUES  = 8;
  localparam int QID_W   = 3;
  localparam int WORD_W  = 32;
  localparam int PTR_W   = $clog2(ENTRIES + 1);
  localparam int ADDR_W  = $clog2(ENTRIES);

  typedef logic [PTR_W-1:0] ptr_t;

  // null pointer is the entry count itself
  localparam ptr_t NULL_PTR = PTR_W'(ENTRIES);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic issue;   // item accepted, start the memory reads
    logic commit;  // apply pointer and memory writes, load result
  } sbmq_cmd_t;

  function automatic logic is_entry(ptr_t p);
    return 32'(p) < ENTRIES;
  endfunction

  function automatic logic queue_ok(logic [QID_W-1:0] q);
    return 32'(q) < QUEUES;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sbmq_ctrl.sv =====
// Controller: two-step sequencer and result valid flag.
`default_nettype none
module sbmq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sbmq_pkg::sbmq_cmd_t     cmd
);
  import sbmq_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.issue  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold here while the previous result is still unclaimed
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sbmq_dpath.sv =====
// Datapath: queue pointers, free list head, link and word memories, result register.
`default_nettype none
module sbmq_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sbmq_pkg::sbmq_cmd_t           cmd,
  input  wire logic                          in_mode,
  input  wire logic [sbmq_pkg::QID_W-1:0]    in_qid,
  input  wire logic [sbmq_pkg::WORD_W-1:0]   in_word,
  output sbmq_pkg::status_t                  out_status,
  output logic [sbmq_pkg::WORD_W-1:0]        out_word
);
  import sbmq_pkg::*;

  ptr_t heads [QUEUES];
  ptr_t tails [QUEUES];
  ptr_t free_head;

  ptr_t              link_mem [ENTRIES];
  logic              link_vld [ENTRIES];
  logic [WORD_W-1:0] word_mem [ENTRIES];

  // operation latched at accept
  logic              op_r;
  logic [QID_W-1:0]  q_r;
  logic [WORD_W-1:0] word_r;
  ptr_t              slot_r;
  ptr_t              link_rd;
  logic              link_vld_r;
  logic [WORD_W-1:0] word_rd;

  ptr_t rd_ptr;

  // execute-step results
  ptr_t              link_val;
  ptr_t              head_x;
  ptr_t              tail_x;
  logic              q_ok_x;
  logic              lw_en;
  ptr_t              lw_addr;
  ptr_t              lw_data;
  logic              ww_en;
  logic              head_we;
  ptr_t              head_val;
  logic              tail_we;
  ptr_t              tail_val;
  logic              fh_we;
  ptr_t              fh_val;
  status_t           st;
  logic [WORD_W-1:0] pw;

  always_comb begin
    rd_ptr = free_head;
    if (in_mode == OP_POP) begin
      rd_ptr = queue_ok(in_qid) ? heads[in_qid] : NULL_PTR;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      op_r       <= in_mode;
      q_r        <= in_qid;
      word_r     <= in_word;
      slot_r     <= rd_ptr;
      link_rd    <= link_mem[rd_ptr[ADDR_W-1:0]];
      link_vld_r <= link_vld[rd_ptr[ADDR_W-1:0]];
      word_rd    <= word_mem[rd_ptr[ADDR_W-1:0]];
    end
  end

  always_comb begin
    q_ok_x   = queue_ok(q_r);
    head_x   = q_ok_x ? heads[q_r] : NULL_PTR;
    tail_x   = q_ok_x ? tails[q_r] : NULL_PTR;
    // a link never written still holds its reset value: next entry up
    link_val = link_vld_r ? link_rd : slot_r + PTR_W'(1);
    lw_en    = 1'b0;
    lw_addr  = slot_r;
    lw_data  = free_head;
    ww_en    = 1'b0;
    head_we  = 1'b0;
    head_val = slot_r;
    tail_we  = 1'b0;
    tail_val = slot_r;
    fh_we    = 1'b0;
    fh_val   = link_val;
    st       = STAT_DONE;
    pw       = '0;
    if (op_r == OP_PUSH) begin
      if (!q_ok_x || !is_entry(slot_r)) begin
        st = STAT_FULL;
      end else begin
        fh_we   = 1'b1;
        ww_en   = 1'b1;
        tail_we = 1'b1;
        if (!is_entry(head_x) || !is_entry(tail_x)) begin
          head_we = 1'b1;
        end else begin
          lw_en   = 1'b1;
          lw_addr = tail_x;
          lw_data = slot_r;
        end
      end
    end else begin
      if (!q_ok_x || !is_entry(slot_r)) begin
        st = STAT_EMPTY;
      end else begin
        // the tail's link is left stale, so the last entry is found by
        // comparing against the tail pointer
        head_we = 1'b1;
        if (slot_r == tail_x) begin
          head_val = NULL_PTR;
          tail_we  = 1'b1;
          tail_val = NULL_PTR;
        end else begin
          head_val = link_val;
        end
        lw_en  = 1'b1;
        fh_we  = 1'b1;
        fh_val = slot_r;
        pw     = word_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUES; i++) begin
        heads[i] <= NULL_PTR;
        tails[i] <= NULL_PTR;
      end
      free_head <= '0;
    end else if (cmd.commit) begin
      if (head_we) begin
        heads[q_r] <= head_val;
      end
      if (tail_we) begin
        tails[q_r] <= tail_val;
      end
      if (fh_we) begin
        free_head <= fh_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        link_vld[i] <= 1'b0;
      end
    end else if (cmd.commit && lw_en) begin
      link_vld[lw_addr[ADDR_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && lw_en) begin
      link_mem[lw_addr[ADDR_W-1:0]] <= lw_data;
    end
    if (cmd.commit && ww_en) begin
      word_mem[slot_r[ADDR_W-1:0]] <= word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= st;
      out_word   <= pw;
    end
  end

`ifndef NO_ASSERTIONS
  a_free_head_range: assert property (@(posedge clk) disable iff (rst)
    32'(free_head) <= ENTRIES)
    else $error("free list head out of range");

  a_head_tail_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && q_ok_x |-> (is_entry(head_x) == is_entry(tail_x)))
    else $error("queue head and tail disagree on emptiness");

  a_refused_no_change: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && (st != STAT_DONE) |=> $stable(free_head))
    else $error("refused operation moved the free list");

  a_pop_word_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && (op_r == OP_PUSH || st == STAT_EMPTY) |=> (out_word == '0))
    else $error("nonzero word on push or refused pop");
`endif

endmodule
`default_nettype wire

// ===== rtl/shared_buffer_multi_queue.sv =====
// Top level: several FIFO queues sharing one linked store with a free list.
//
//  channel  dir  tdata                                   tuser
//  s_axis   in   [2:0] queue_id, [34:3] push_word, pad   [0] mode (0 push, 1 pop)
//  m_axis   out  [31:0] pop_word                         [1:0] status
//
// Each item has an accept step and an execute step. The accept edge reads the
// link and word memories at the free list head (push) or queue head (pop); the
// execute edge writes the pointers, at most one link entry and, on a push, the
// word entry, and loads the result register; the dependent link read then write
// thus suits the single-port link memory. Reset is synchronous; link entries
// carry valid bits so the free list starts as entry 0, 1, 2 and up, with no
// clearing pass. A waiting result does not block the next accept; only execute waits on it.
`default_nettype none
module shared_buffer_multi_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // queue_id[2:0], push_word[34:3], zero pad
  input  wire logic        s_axis_tuser,   // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // pop_word
  output logic [1:0]       m_axis_tuser    // status
);
  import sbmq_pkg::*;

  sbmq_cmd_t cmd;
  status_t   out_status;

  sbmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  sbmq_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_mode    (s_axis_tuser),
    .in_qid     (s_axis_tdata[QID_W-1:0]),
    .in_word    (s_axis_tdata[QID_W+WORD_W-1:QID_W]),
    .out_status (out_status),
    .out_word   (m_axis_tdata)
  );

  assign m_axis_tuser = out_status;

endmodule
`default_nettype wire
